### design/ffa_pkg.sv
package ffa_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int LIVE_ENTRIES = 16;
  localparam int ADDR_W = 32;
  localparam int LEN_W = ADDR_W;
  localparam int SIZE_W = 24;
  localparam int HDR_W = 7;
  localparam int GROW_W = 25;
  localparam int REL_W = 25;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int F_IDX_W = $clog2(FREE_ENTRIES);
  localparam int F_CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int L_IDX_W = $clog2(LIVE_ENTRIES);
  localparam int L_CNT_W = $clog2(LIVE_ENTRIES + 1);
  localparam int IDX_W = (F_CNT_W > L_CNT_W) ? F_CNT_W : L_CNT_W;
  localparam int NEED_W = ((SIZE_W > HDR_W) ? SIZE_W : HDR_W) + 1;
  localparam int G_W = (GROW_W > NEED_W) ? GROW_W : NEED_W;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = ADDR_W'(65536);
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = ADDR_W'(16777216);
  localparam logic [HDR_W-1:0] HEADER_RST = HDR_W'(24);
  localparam logic [GROW_W-1:0] GROW_RST = GROW_W'(12288);
  localparam logic [REL_W-1:0] MIN_REL_RST = REL_W'(4096);

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef enum logic [0:0] {CMD_ALLOC, CMD_FREE} cmd_e;

  typedef enum logic [1:0] {ST_OK, ST_OOM, ST_FULL, ST_UNKNOWN} status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE,
    CFG_HEAP_LIMIT,
    CFG_HEADER_SIZE,
    CFG_GROW_UNIT,
    CFG_MIN_RELEASE
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INC, OP_RES_FULL, OP_RES_UNKNOWN, OP_GROW, OP_TAKE_SPLIT,
    OP_TAKE_WHOLE, OP_FDEL, OP_LHIT, OP_PSTEP, OP_PFIX, OP_LDEL, OP_MERGE, OP_INS,
    OP_REL, OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_FDEL_R, S_FDEL_M, S_LSCAN, S_PSCAN, S_LDEL, S_MERGE, S_INS,
    S_REL, S_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic live_full;
    logic free_full;
    logic at_end;
    logic fit;
    logic split;
    logic l_end;
    logic hit;
    logic pos_go;
    logic mp;
    logic mn;
    logic mp_saved;
    logic mn_saved;
    logic del_last;
    logic ldel_last;
    logic ins_done;
    logic rel_ok;
  } dp_stat_t;

endpackage

### design/ffa_req_if.sv
interface ffa_req_if import ffa_pkg::*; ();
  logic valid;
  logic ready;
  logic command;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, command, size_bytes, block_address, input ready);
  modport sink (input valid, command, size_bytes, block_address, output ready);
endinterface

### design/ffa_rsp_if.sv
interface ffa_rsp_if import ffa_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [ADDR_W-1:0] payload_address;
  logic [ADDR_W-1:0] break_address;
  logic released;

  modport source (output valid, status, payload_address, break_address, released,
                  input ready);
  modport sink (input valid, status, payload_address, break_address, released,
                output ready);
endinterface

### design/ffa_datapath.sv
module ffa_datapath import ffa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic [SIZE_W-1:0]     req_size_i,
  input  logic [ADDR_W-1:0]     req_addr_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output status_e               rsp_status_o,
  output logic [ADDR_W-1:0]     rsp_payload_o,
  output logic [ADDR_W-1:0]     rsp_break_o,
  output logic                  rsp_released_o
);

  logic [ADDR_W-1:0] heap_limit_q;
  logic [HDR_W-1:0] hdr_q;
  logic [GROW_W-1:0] grow_q;
  logic [REL_W-1:0] minrel_q;

  seg_t free_q [FREE_ENTRIES];
  seg_t live_q [LIVE_ENTRIES];
  logic [F_CNT_W-1:0] fcnt_q;
  logic [L_CNT_W-1:0] lcnt_q;
  logic [ADDR_W-1:0] brk_q;
  logic [IDX_W-1:0] idx_q;
  logic [F_CNT_W-1:0] pos_q;
  logic [L_IDX_W-1:0] li_q;
  logic pv_q, mp_q, mn_q;

  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q, s_q;
  logic [LEN_W-1:0] t_q;
  seg_t prev_q;
  status_e res_status_q, out_status_q;
  logic [ADDR_W-1:0] res_payload_q, out_payload_q, out_break_q;
  logic res_rel_q, out_rel_q;

  logic [F_IDX_W-1:0] f_rd;
  logic [L_IDX_W-1:0] l_rd;
  seg_t cur, lcur;
  logic [NEED_W-1:0] need;
  logic [NEED_W:0] need_h;
  logic [LEN_W-1:0] rem, merge_len;
  logic [G_W-1:0] g, rem_g;
  logic [ADDR_W-1:0] lhdr;
  logic [ADDR_W:0] prev_end, blk_end, cur_end;
  logic [REL_W:0] minrel_h;
  logic fit, split, oom, split_g, cur_valid, mp, mn, free_full, live_full, rel_ok;
  logic del_last, ldel_last, grow_ok;

  always_comb begin
    unique case (cmd_i.op)
      OP_MERGE: f_rd = pos_q[F_IDX_W-1:0];
      OP_REL:   f_rd = F_IDX_W'(fcnt_q - 1'b1);
      OP_INS:   f_rd = F_IDX_W'(idx_q - 1'b1);
      OP_FDEL:  f_rd = F_IDX_W'(idx_q + 1'b1);
      default:  f_rd = idx_q[F_IDX_W-1:0];
    endcase
    l_rd = (cmd_i.op == OP_LDEL) ? L_IDX_W'(idx_q + 1'b1) : idx_q[L_IDX_W-1:0];
  end

  assign cur = free_q[f_rd];
  assign lcur = live_q[l_rd];

  assign need = NEED_W'(size_q) + NEED_W'(hdr_q);
  assign need_h = (NEED_W+1)'(need) + (NEED_W+1)'(hdr_q);
  assign fit = cur.len >= LEN_W'(need_h);
  assign rem = cur.len - LEN_W'(need);
  assign split = (rem != '0) && (rem >= LEN_W'(hdr_q));

  assign g = (G_W'(grow_q) > G_W'(need)) ? G_W'(grow_q) : G_W'(need);
  assign oom = (ADDR_W'(g) > heap_limit_q) || (brk_q > heap_limit_q - ADDR_W'(g));
  assign rem_g = g - G_W'(need);
  assign split_g = (rem_g != '0) && (rem_g >= G_W'(hdr_q));
  assign free_full = fcnt_q == F_CNT_W'(FREE_ENTRIES);
  assign live_full = lcnt_q == L_CNT_W'(LIVE_ENTRIES);
  assign grow_ok = !oom && !(split_g && free_full);

  assign lhdr = lcur.start + ADDR_W'(hdr_q);
  assign cur_valid = idx_q < IDX_W'(fcnt_q);
  assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
  assign blk_end = {1'b0, s_q} + {1'b0, t_q};
  assign mp = pv_q && (prev_end == {1'b0, s_q});
  assign mn = cur_valid && (blk_end == {1'b0, cur.start});
  assign merge_len = prev_q.len + t_q + (mn_q ? cur.len : '0);

  assign cur_end = {1'b0, cur.start} + {1'b0, cur.len};
  assign minrel_h = (REL_W+1)'(minrel_q) + (REL_W+1)'(hdr_q);
  assign rel_ok = (fcnt_q != '0) && (cur_end == {1'b0, brk_q}) &&
                  (cur.len >= LEN_W'(minrel_h));

  assign del_last = ({1'b0, idx_q} + 1'b1) >= (IDX_W+1)'(fcnt_q);
  assign ldel_last = ({1'b0, idx_q} + 1'b1) >= (IDX_W+1)'(lcnt_q);

  always_comb begin
    stat_o.live_full = live_full;
    stat_o.free_full = free_full;
    stat_o.at_end = !cur_valid;
    stat_o.fit = fit;
    stat_o.split = split;
    stat_o.l_end = !(idx_q < IDX_W'(lcnt_q));
    stat_o.hit = lhdr == addr_q;
    stat_o.pos_go = cur_valid && (cur.start <= s_q);
    stat_o.mp = mp;
    stat_o.mn = mn;
    stat_o.mp_saved = mp_q;
    stat_o.mn_saved = mn_q;
    stat_o.del_last = del_last;
    stat_o.ldel_last = ldel_last;
    stat_o.ins_done = idx_q <= IDX_W'(pos_q);
    stat_o.rel_ok = rel_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HEAP_LIMIT_RST;
      hdr_q <= HEADER_RST;
      grow_q <= GROW_RST;
      minrel_q <= MIN_REL_RST;
      fcnt_q <= '0;
      lcnt_q <= '0;
      brk_q <= HEAP_BASE_RST;
      idx_q <= '0;
      pos_q <= '0;
      li_q <= '0;
      pv_q <= 1'b0;
      mp_q <= 1'b0;
      mn_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          idx_q <= '0;
          pv_q <= 1'b0;
        end
        OP_INC: idx_q <= idx_q + 1'b1;
        OP_GROW: begin
          if (grow_ok) begin
            brk_q <= brk_q + ADDR_W'(g);
            lcnt_q <= lcnt_q + 1'b1;
            if (split_g) fcnt_q <= fcnt_q + 1'b1;
          end
        end
        OP_TAKE_SPLIT, OP_TAKE_WHOLE: lcnt_q <= lcnt_q + 1'b1;
        OP_FDEL: begin
          if (del_last) fcnt_q <= fcnt_q - 1'b1;
          else idx_q <= idx_q + 1'b1;
        end
        OP_LHIT: begin
          li_q <= idx_q[L_IDX_W-1:0];
          idx_q <= '0;
          pv_q <= 1'b0;
        end
        OP_PSTEP: begin
          pv_q <= 1'b1;
          idx_q <= idx_q + 1'b1;
        end
        OP_PFIX: begin
          pos_q <= F_CNT_W'(idx_q);
          mp_q <= mp;
          mn_q <= mn;
          idx_q <= IDX_W'(li_q);
        end
        OP_LDEL: begin
          if (ldel_last) lcnt_q <= lcnt_q - 1'b1;
          else idx_q <= idx_q + 1'b1;
        end
        OP_MERGE: idx_q <= (mp_q && mn_q) ? IDX_W'(pos_q) : IDX_W'(fcnt_q);
        OP_INS: begin
          if (idx_q > IDX_W'(pos_q)) idx_q <= idx_q - 1'b1;
          else fcnt_q <= fcnt_q + 1'b1;
        end
        OP_REL: begin
          if (rel_ok) begin
            brk_q <= cur.start;
            idx_q <= IDX_W'(fcnt_q - 1'b1);
          end
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_HEAP_BASE: begin
            // The base only matters while the heap is empty, so it goes straight
            // into the break.
            if (fcnt_q == '0 && lcnt_q == '0) brk_q <= ADDR_W'(cfg_data_i);
          end
          CFG_HEAP_LIMIT: heap_limit_q <= ADDR_W'(cfg_data_i);
          CFG_HEADER_SIZE: hdr_q <= cfg_data_i[HDR_W-1:0];
          CFG_GROW_UNIT: grow_q <= cfg_data_i[GROW_W-1:0];
          CFG_MIN_RELEASE: minrel_q <= cfg_data_i[REL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        size_q <= req_size_i;
        addr_q <= req_addr_i;
        res_status_q <= ST_OK;
        res_payload_q <= '0;
        res_rel_q <= 1'b0;
      end
      OP_RES_FULL: res_status_q <= ST_FULL;
      OP_RES_UNKNOWN: res_status_q <= ST_UNKNOWN;
      OP_GROW: begin
        if (oom) begin
          res_status_q <= ST_OOM;
        end else if (split_g && free_full) begin
          res_status_q <= ST_FULL;
        end else begin
          live_q[lcnt_q[L_IDX_W-1:0]] <= '{start: brk_q,
                                          len: split_g ? LEN_W'(need) : LEN_W'(g)};
          if (split_g) begin
            free_q[fcnt_q[F_IDX_W-1:0]] <= '{start: brk_q + ADDR_W'(need),
                                            len: LEN_W'(rem_g)};
          end
          res_payload_q <= brk_q + ADDR_W'(hdr_q);
        end
      end
      OP_TAKE_SPLIT: begin
        free_q[idx_q[F_IDX_W-1:0]] <= '{start: cur.start + ADDR_W'(need), len: rem};
        live_q[lcnt_q[L_IDX_W-1:0]] <= '{start: cur.start, len: LEN_W'(need)};
        res_payload_q <= cur.start + ADDR_W'(hdr_q);
      end
      OP_TAKE_WHOLE: begin
        live_q[lcnt_q[L_IDX_W-1:0]] <= cur;
        res_payload_q <= cur.start + ADDR_W'(hdr_q);
      end
      OP_FDEL: begin
        if (!del_last) free_q[idx_q[F_IDX_W-1:0]] <= cur;
      end
      OP_LHIT: begin
        s_q <= lcur.start;
        t_q <= lcur.len;
      end
      OP_PSTEP: prev_q <= cur;
      OP_LDEL: begin
        if (!ldel_last) live_q[idx_q[L_IDX_W-1:0]] <= lcur;
      end
      OP_MERGE: begin
        if (mp_q) begin
          free_q[F_IDX_W'(pos_q - 1'b1)] <= '{start: prev_q.start, len: merge_len};
        end else if (mn_q) begin
          free_q[pos_q[F_IDX_W-1:0]] <= '{start: s_q, len: cur.len + t_q};
        end
      end
      OP_INS: begin
        if (idx_q > IDX_W'(pos_q)) free_q[idx_q[F_IDX_W-1:0]] <= cur;
        else free_q[pos_q[F_IDX_W-1:0]] <= '{start: s_q, len: t_q};
      end
      OP_REL: begin
        if (rel_ok) res_rel_q <= 1'b1;
      end
      OP_OUT: begin
        out_status_q <= res_status_q;
        out_payload_q <= res_payload_q;
        out_break_q <= brk_q;
        out_rel_q <= res_rel_q;
      end
      default: ;
    endcase
  end

  assign rsp_status_o = out_status_q;
  assign rsp_payload_o = out_payload_q;
  assign rsp_break_o = out_break_q;
  assign rsp_released_o = out_rel_q;

endmodule

### design/ffa_controller.sv
module ffa_controller import ffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_cmd_i,
  output logic     req_ready_o,
  input  logic     rsp_ready_i,
  output logic     rsp_valid_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    req_ready_o = 1'b0;
    valid_d = valid_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = (cmd_e'(req_cmd_i) == CMD_FREE) ? S_LSCAN : S_ASCAN;
        end
      end
      S_ASCAN: begin
        priority if (stat_i.live_full) begin
          cmd_o.op = OP_RES_FULL;
          state_d = S_DONE;
        end else if (stat_i.at_end) begin
          cmd_o.op = OP_GROW;
          state_d = S_DONE;
        end else if (stat_i.fit) begin
          cmd_o.op = stat_i.split ? OP_TAKE_SPLIT : OP_TAKE_WHOLE;
          state_d = stat_i.split ? S_DONE : S_FDEL_R;
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_FDEL_R, S_FDEL_M: begin
        cmd_o.op = OP_FDEL;
        if (stat_i.del_last) state_d = (state_q == S_FDEL_R) ? S_DONE : S_REL;
      end
      S_LSCAN: begin
        priority if (stat_i.l_end) begin
          cmd_o.op = OP_RES_UNKNOWN;
          state_d = S_DONE;
        end else if (stat_i.hit) begin
          cmd_o.op = OP_LHIT;
          state_d = S_PSCAN;
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_PSCAN: begin
        priority if (stat_i.pos_go) begin
          cmd_o.op = OP_PSTEP;
        end else if (!stat_i.mp && !stat_i.mn && stat_i.free_full) begin
          cmd_o.op = OP_RES_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_PFIX;
          state_d = S_LDEL;
        end
      end
      S_LDEL: begin
        cmd_o.op = OP_LDEL;
        if (stat_i.ldel_last) state_d = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.op = OP_MERGE;
        if (stat_i.mp_saved) state_d = stat_i.mn_saved ? S_FDEL_M : S_REL;
        else state_d = stat_i.mn_saved ? S_REL : S_INS;
      end
      S_INS: begin
        cmd_o.op = OP_INS;
        if (stat_i.ins_done) state_d = S_REL;
      end
      S_REL: begin
        cmd_o.op = OP_REL;
        state_d = stat_i.rel_ok ? S_FDEL_R : S_DONE;
      end
      S_DONE: begin
        if (!valid_q || rsp_ready_i) begin
          cmd_o.op = OP_OUT;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_o = valid_q;

endmodule

### design/first_fit_heap_allocator_top.sv
// First-fit heap allocator with full coalescing over a region that ends at a movable
// break. One request is worked at a time; the result sits in an output register, so
// the next request can be taken while it waits. A sequencer walks the free and live
// tables one entry per cycle for the search, and shifting an entry in or out of a
// table moves the entries behind it one at a time. A result that is not taken stalls
// the next request in its final cycle. Configuration is written through
// cfg_we_i/cfg_index_i/cfg_data_i while no request is in flight.
module first_fit_heap_allocator_top import ffa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ffa_req_if.sink               req,
  ffa_rsp_if.source             rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_stat_t stat;
  status_e status;

  ffa_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_cmd_i   (req.command),
    .req_ready_o (req.ready),
    .rsp_ready_i (rsp.ready),
    .rsp_valid_o (rsp.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_size_i     (req.size_bytes),
    .req_addr_i     (req.block_address),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rsp_status_o   (status),
    .rsp_payload_o  (rsp.payload_address),
    .rsp_break_o    (rsp.break_address),
    .rsp_released_o (rsp.released)
  );

  assign rsp.status = status;

endmodule

### design/ffa_checker.sv
module ffa_checker import ffa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic [ADDR_W-1:0] rsp_payload_i,
  input logic              rsp_released_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result changed while stalled");

  a_err_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_payload_i == '0 && !rsp_released_i)
    else $error("failed request carries a payload or release");

  a_release_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_released_i |-> rsp_payload_i == '0)
    else $error("release reported on an allocate");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_status_i   (rsp.status),
  .rsp_payload_i  (rsp.payload_address),
  .rsp_released_i (rsp.released)
);
